// ===== rtl/core/mfbs_pkg.sv =====
// mfbs_pkg: shared types, constants and the start code classifier
// used by the frame boundary scanner interfaces and core modules
`default_nettype none

package mfbs_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HIST_W    = 3 * BYTE_W;
    localparam int unsigned CLASS_W   = 3;

    localparam logic [HIST_W-1:0] HIST_RESET = 24'hFF_FFFF;
    localparam logic [HIST_W-1:0] PREFIX     = 24'h00_0001;

    localparam logic [BYTE_W-1:0] CODE_PICTURE   = 8'h00;
    localparam logic [BYTE_W-1:0] CODE_SLICE_LO  = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_SLICE_HI  = 8'hAF;
    localparam logic [BYTE_W-1:0] CODE_USER      = 8'hB2;
    localparam logic [BYTE_W-1:0] CODE_SEQUENCE  = 8'hB3;
    localparam logic [BYTE_W-1:0] CODE_EXTENSION = 8'hB5;
    localparam logic [BYTE_W-1:0] CODE_GOP       = 8'hB8;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE      = 3'd0,
        CLS_PICTURE   = 3'd1,
        CLS_SLICE     = 3'd2,
        CLS_USER      = 3'd3,
        CLS_SEQUENCE  = 3'd4,
        CLS_EXTENSION = 3'd5,
        CLS_GOP       = 3'd6,
        CLS_OTHER     = 3'd7
    } t_code_class;

    function automatic t_code_class classify(input t_byte v);
        t_code_class c;
        if (v == CODE_PICTURE) begin
            c = CLS_PICTURE;
        end else if (v >= CODE_SLICE_LO && v <= CODE_SLICE_HI) begin
            c = CLS_SLICE;
        end else if (v == CODE_USER) begin
            c = CLS_USER;
        end else if (v == CODE_SEQUENCE) begin
            c = CLS_SEQUENCE;
        end else if (v == CODE_EXTENSION) begin
            c = CLS_EXTENSION;
        end else if (v == CODE_GOP) begin
            c = CLS_GOP;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mfbs_ifs.sv =====
// mfbs_ifs: valid/ready channel interfaces for stream bytes and scan results
// depends on mfbs_pkg
`default_nettype none

interface mfbs_byte_if;
    import mfbs_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mfbs_result_if;
    import mfbs_pkg::*;

    logic        valid;
    logic        ready;
    logic        code_found;
    t_byte       code_value;
    t_code_class code_class;
    logic        frame_end;
    logic        frame_open;

    modport source (output valid, output code_found, output code_value,
                    output code_class, output frame_end, output frame_open,
                    input ready);
    modport sink   (input valid, input code_found, input code_value,
                    input code_class, input frame_end, input frame_open,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mfbs_in_reg.sv =====
// mfbs_in_reg: input register stage for stream bytes
// depends on mfbs_pkg and mfbs_ifs
`default_nettype none

module mfbs_in_reg (
    input  wire            i_clk,
    input  wire            i_rst_n,
    mfbs_byte_if.sink      i_byte,
    input  wire            i_advance,
    output logic           o_valid,
    output mfbs_pkg::t_byte o_data
);
    import mfbs_pkg::*;

    logic  r_valid;
    t_byte r_data;
    logic  n_valid;

    // register may take a new byte when empty or when its content moves on
    assign i_byte.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_byte.ready) begin
            n_valid = i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_data <= i_byte.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/mfbs_detect.sv =====
// mfbs_detect: byte history, start code detection, frame tracking and result register
// depends on mfbs_pkg and mfbs_ifs
`default_nettype none

module mfbs_detect (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire mfbs_pkg::t_byte i_data,
    output logic            o_advance,
    mfbs_result_if.source   o_result
);
    import mfbs_pkg::*;

    logic [HIST_W-1:0] r_hist;
    logic              r_in_frame;
    logic [HIST_W-1:0] n_hist;
    logic              n_in_frame;

    logic        r_out_valid;
    logic        r_found;
    t_byte       r_value;
    t_code_class r_class;
    logic        r_end;
    logic        r_open;

    logic        found;
    t_code_class cls;
    logic        ends;

    assign o_advance = i_valid && (!r_out_valid || o_result.ready);

    always_comb begin
        found      = (r_hist == PREFIX);
        cls        = found ? classify(i_data) : CLS_NONE;
        ends       = 1'b0;
        n_in_frame = r_in_frame;
        n_hist     = {r_hist[HIST_W-BYTE_W-1:0], i_data};
        if (found && !r_in_frame && cls == CLS_SLICE) begin
            n_in_frame = 1'b1;
        end else if (found && r_in_frame && cls != CLS_SLICE) begin
            // closing code bytes may not seed a later prefix
            ends       = 1'b1;
            n_in_frame = 1'b0;
            n_hist     = HIST_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= HIST_RESET;
            r_in_frame  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_hist     <= n_hist;
                r_in_frame <= n_in_frame;
            end
            if (o_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_found <= found;
            r_value <= found ? i_data : '0;
            r_class <= cls;
            r_end   <= ends;
            r_open  <= n_in_frame;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.code_found = r_found;
    assign o_result.code_value = r_value;
    assign o_result.code_class = r_class;
    assign o_result.frame_end  = r_end;
    assign o_result.frame_open = r_open;

endmodule

`default_nettype wire

// ===== rtl/core/mpeg_frame_boundary_scanner.sv =====
// mpeg_frame_boundary_scanner: start code scanner and frame boundary finder, top level
// result path: a byte passes the input register, then the result register in mfbs_detect
// throughput: one byte per cycle while o_result.ready is high; mfbs_detect updates the history once per byte
// reset (synchronous, active low): both stages empty, history all ones, no frame open
// depends on mfbs_pkg, mfbs_ifs, mfbs_in_reg, mfbs_detect
`default_nettype none

module mpeg_frame_boundary_scanner (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mfbs_byte_if.sink     i_byte,
    mfbs_result_if.source o_result
);
    import mfbs_pkg::*;

    logic  s1_valid;
    t_byte s1_data;
    logic  s1_advance;

    mfbs_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (s1_advance),
        .o_valid   (s1_valid),
        .o_data    (s1_data)
    );

    mfbs_detect u_detect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s1_valid),
        .i_data    (s1_data),
        .o_advance (s1_advance),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
